[hw/rtl/lrcm_pkg.sv]
// Package for the low-rank correction matvec block.
// Field widths, command and status codes, default sizes. No dependencies.
`default_nettype none
package lrcm_pkg;
  localparam int LAYERS_DEF   = 4;
  localparam int MAX_IN_DEF   = 1024;
  localparam int MAX_RANK_DEF = 16;
  localparam int MAX_OUT_DEF  = 64;

  localparam int LAYER_W = 3;
  localparam int INDEX_W = 14;
  localparam int VALUE_W = 16;
  localparam int IN_W    = 11;
  localparam int OUT_W   = 7;
  localparam int RANK_W  = 5;
  localparam int RES_W   = 32;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 32;

  localparam logic [1:0] CMD_SIZES = 2'd0;
  localparam logic [1:0] CMD_A     = 2'd1;
  localparam logic [1:0] CMD_B     = 2'd2;
  localparam logic [1:0] CMD_X     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNLOADED = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_LEN      = 2'd3;

  localparam logic [IN_W-1:0] COUNT_MAX = 11'd2047;
endpackage
`default_nettype wire

[hw/rtl/low_rank_correction_matvec.sv]
// Low-rank correction y = B*(A*x), top level.
// Depends on lrcm_pkg.
//
// Usage: one input stream (s_axis) carries commands, one output stream
// (m_axis) carries results. tuser on the input is the command: load sizes,
// load A weight, load B weight, x element. tlast marks the last x element.
// An x element for a ready layer, with the element count below its input
// size, closes the input for its rank steps: the accumulators live in a
// memory, and each rank step reads the A memory and the accumulator entry,
// then writes the sum back. Other x elements are only counted. On the last
// element the tail passes S_FIN, then per output accumulates over the rank
// (S_TRD, S_TMAC) and forms the beat in S_TOUT; each beat is valid the cycle
// after it is formed. Beats sit in an output register until taken. While it
// is full the tail waits before forming the next beat; once the last beat is
// formed the input opens again, even while that beat waits.
// Reset clears layer sizes, ready flags, accumulator valid bits, the output
// valid bit and the element count; the A and B memories are not cleared and
// hold anything until written.
`default_nettype none
module low_rank_correction_matvec
  import lrcm_pkg::*;
#(
  parameter int LAYERS   = LAYERS_DEF,
  parameter int MAX_IN   = MAX_IN_DEF,
  parameter int MAX_RANK = MAX_RANK_DEF,
  parameter int MAX_OUT  = MAX_OUT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // layer[2:0] index[16:3] value[32:17] in_size[43:33] out_size[50:44]
  // rank_size[55:51]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]           s_axis_tuser,
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // result[31:0]
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]                m_axis_tuser,
  output logic                      m_axis_tlast
);
  localparam int A_BANK = MAX_RANK * MAX_IN;
  localparam int B_BANK = MAX_OUT * MAX_RANK;
  localparam int A_DEPTH = LAYERS * A_BANK;
  localparam int B_DEPTH = LAYERS * B_BANK;
  localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int LW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int RW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int ACC_W = 48;
  localparam int S_W   = 53;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;
  localparam logic [2:0] S_MWB  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_TRD  = 3'd4;
  localparam logic [2:0] S_TMAC = 3'd5;
  localparam logic [2:0] S_TOUT = 3'd6;

  logic [2:0] state_q, state_d;

  logic [LAYER_W-1:0] in_layer;
  logic [INDEX_W-1:0] in_index;
  logic signed [VALUE_W-1:0] in_value;
  logic [IN_W-1:0]   in_isz;
  logic [OUT_W-1:0]  in_osz;
  logic [RANK_W-1:0] in_rsz;
  assign in_layer = s_axis_tdata[2:0];
  assign in_index = s_axis_tdata[16:3];
  assign in_value = s_axis_tdata[32:17];
  assign in_isz   = s_axis_tdata[43:33];
  assign in_osz   = s_axis_tdata[50:44];
  assign in_rsz   = s_axis_tdata[55:51];

  logic [IN_W-1:0]   sz_in_q  [LAYERS];
  logic [OUT_W-1:0]  sz_out_q [LAYERS];
  logic [RANK_W-1:0] sz_rank_q[LAYERS];
  logic [LAYERS-1:0] ready_q;

  logic acc_in;
  logic lok;
  logic [LW-1:0] lidx;
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc_in = s_axis_tvalid & s_axis_tready;
  assign lok = ({29'd0, in_layer} < LAYERS);
  assign lidx = in_layer[LW-1:0];

  logic [IN_W-1:0] isz_c;
  logic [OUT_W-1:0] osz_c;
  logic [RANK_W-1:0] rsz_c;
  always_comb begin
    isz_c = in_isz;
    if (in_isz == '0) isz_c = IN_W'(1);
    else if (in_isz > IN_W'(MAX_IN)) isz_c = IN_W'(MAX_IN);
    osz_c = in_osz;
    if (in_osz == '0) osz_c = OUT_W'(1);
    else if (in_osz > OUT_W'(MAX_OUT)) osz_c = OUT_W'(MAX_OUT);
    rsz_c = in_rsz;
    if (in_rsz == '0) rsz_c = RANK_W'(1);
    else if (in_rsz > RANK_W'(MAX_RANK)) rsz_c = RANK_W'(MAX_RANK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= '0;
      for (int i = 0; i < LAYERS; i++) begin
        sz_in_q[i]   <= '0;
        sz_out_q[i]  <= '0;
        sz_rank_q[i] <= '0;
      end
    end else if (acc_in && s_axis_tuser == CMD_SIZES && lok) begin
      sz_in_q[lidx]   <= isz_c;
      sz_out_q[lidx]  <= osz_c;
      sz_rank_q[lidx] <= rsz_c;
      ready_q[lidx]   <= 1'b1;
    end
  end

  // weight memories
  logic signed [VALUE_W-1:0] a_mem [A_DEPTH];
  logic signed [VALUE_W-1:0] b_mem [B_DEPTH];
  logic signed [VALUE_W-1:0] a_rd_q, b_rd_q;
  logic a_we, b_we;
  logic [AAW-1:0] a_waddr, a_raddr;
  logic [BAW-1:0] b_waddr, b_raddr;

  logic [LAYER_W-1:0] layer_q;
  logic [AAW-1:0] off_q;
  logic [BAW-1:0] boff_q;

  assign a_we = acc_in && s_axis_tuser == CMD_A && lok && ({18'd0, in_index} < A_BANK);
  assign b_we = acc_in && s_axis_tuser == CMD_B && lok && ({18'd0, in_index} < B_BANK);
  assign a_waddr = AAW'(in_layer) * AAW'(A_BANK) + AAW'(in_index);
  assign b_waddr = BAW'(in_layer) * BAW'(B_BANK) + BAW'(in_index);
  assign a_raddr = AAW'(layer_q) * AAW'(A_BANK) + off_q;
  assign b_raddr = BAW'(layer_q) * BAW'(B_BANK) + boff_q;

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[a_waddr] <= in_value;
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[b_waddr] <= in_value;
    b_rd_q <= b_mem[b_raddr];
  end

  // accumulator memory, valid bits give the zero reset
  logic signed [ACC_W-1:0] acc_mem [MAX_RANK];
  logic signed [ACC_W-1:0] acc_rd_q, acc_eff, acc_new;
  logic [MAX_RANK-1:0] acc_vld_q;
  logic acc_rv_q;
  logic [RANK_W-1:0] r_q;
  logic [RW-1:0] ridx;
  logic acc_we, clr;
  assign ridx = r_q[RW-1:0];
  assign acc_eff = acc_rv_q ? acc_rd_q : '0;

  logic signed [VALUE_W-1:0] val_q;
  assign acc_new = acc_eff + ACC_W'(val_q * a_rd_q);
  assign acc_we = (state_q == S_MWB);

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[ridx] <= acc_new;
    acc_rd_q <= acc_mem[ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      acc_rv_q  <= 1'b0;
    end else begin
      acc_rv_q <= acc_vld_q[ridx];
      if (clr) acc_vld_q <= '0;
      else if (acc_we) acc_vld_q[ridx] <= 1'b1;
    end
  end

  // tail arithmetic
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [RES_W-1:0] t_val;
  logic signed [S_W-1:0] s_q, s_sh;
  logic signed [RES_W-1:0] y_val;
  assign acc_sh = acc_eff >>> 12;
  always_comb begin
    if (acc_sh > 48'sh0000_7FFF_FFFF) t_val = 32'sh7FFF_FFFF;
    else if (acc_sh < -48'sh0000_8000_0000) t_val = 32'sh8000_0000;
    else t_val = acc_sh[RES_W-1:0];
    s_sh = s_q >>> 12;
    if (s_sh > 53'sh0_0000_7FFF_FFFF) y_val = 32'sh7FFF_FFFF;
    else if (s_sh < -53'sh0_0000_8000_0000) y_val = 32'sh8000_0000;
    else y_val = s_sh[RES_W-1:0];
  end

  // control
  logic [IN_W-1:0] count_q, ind_q;
  logic [RANK_W-1:0] rk_q;
  logic [OUT_W-1:0] od_q, j_q;
  logic last_q, lok_q, rdy_q;
  logic [RES_W-1:0] out_data_q;
  logic [1:0] out_st_q;
  logic out_last_q;
  logic out_vld_q;
  logic out_free, fin_err, e_load, y_load;
  logic [IN_W-1:0] cur_in;
  logic cur_rdy;
  assign cur_in  = lok ? sz_in_q[lidx] : '0;
  assign cur_rdy = lok & ready_q[lidx];

  assign out_free = !out_vld_q || m_axis_tready;
  assign fin_err  = (state_q == S_FIN) && !(lok_q && rdy_q && count_q == ind_q);
  assign e_load   = fin_err && out_free;
  assign y_load   = (state_q == S_TOUT) && out_free;
  assign clr = e_load || (y_load && j_q + OUT_W'(1) == od_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc_in && s_axis_tuser == CMD_X) begin
          if (cur_rdy && count_q < cur_in) state_d = S_MRD;
          else if (s_axis_tlast) state_d = S_FIN;
        end
      end
      S_MRD: state_d = S_MWB;
      S_MWB: begin
        if (r_q + RANK_W'(1) == rk_q) state_d = last_q ? S_FIN : S_IDLE;
        else state_d = S_MRD;
      end
      S_FIN: begin
        if (!fin_err) state_d = S_TRD;
        else if (out_free) state_d = S_IDLE;
      end
      S_TRD: state_d = S_TMAC;
      S_TMAC: state_d = (r_q + RANK_W'(1) == rk_q) ? S_TOUT : S_TRD;
      S_TOUT: begin
        if (out_free) state_d = (j_q + OUT_W'(1) == od_q) ? S_IDLE : S_TRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      r_q       <= '0;
      j_q       <= '0;
      off_q     <= '0;
      boff_q    <= '0;
      last_q    <= 1'b0;
      lok_q     <= 1'b0;
      rdy_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) count_q <= '0;
      if (e_load || y_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc_in && s_axis_tuser == CMD_X) begin
            if (count_q < COUNT_MAX) count_q <= count_q + IN_W'(1);
            last_q <= s_axis_tlast;
            lok_q  <= lok;
            rdy_q  <= cur_rdy;
            r_q    <= '0;
            off_q  <= AAW'(count_q);
          end
        end
        S_MWB: begin
          r_q   <= r_q + RANK_W'(1);
          off_q <= off_q + AAW'(ind_q);
        end
        S_FIN: begin
          r_q    <= '0;
          j_q    <= '0;
          boff_q <= '0;
        end
        S_TMAC: begin
          r_q    <= r_q + RANK_W'(1);
          boff_q <= boff_q + BAW'(1);
        end
        S_TOUT: begin
          if (out_free) begin
            r_q <= '0;
            j_q <= j_q + OUT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tuser == CMD_X) begin
      layer_q <= in_layer;
      val_q   <= in_value;
      ind_q   <= cur_in;
      rk_q    <= lok ? sz_rank_q[lidx] : RANK_W'(1);
      od_q    <= lok ? sz_out_q[lidx] : OUT_W'(1);
    end
    if (state_q == S_FIN || y_load) s_q <= '0;
    else if (state_q == S_TMAC) s_q <= s_q + S_W'(b_rd_q * t_val);
    if (e_load) begin
      out_data_q <= '0;
      out_last_q <= 1'b1;
      if (!lok_q) out_st_q <= ST_BAD;
      else if (!rdy_q) out_st_q <= ST_UNLOADED;
      else out_st_q <= ST_LEN;
    end else if (y_load) begin
      out_data_q <= y_val;
      out_last_q <= (j_q + OUT_W'(1) == od_q);
      out_st_q   <= ST_OK;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;
endmodule
`default_nettype wire

[hw/rtl/lrcm_checker.sv]
// Port-level checks for low_rank_correction_matvec, bound to the top level.
// Depends on lrcm_pkg.
`default_nettype none
module lrcm_checker
  import lrcm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]           m_axis_tuser,
  input wire logic                 m_axis_tlast
);
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast)
    else $error("error beat without tlast");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("error beat with nonzero data");
  a_hold_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled beat changed status or tlast");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");
endmodule

bind low_rank_correction_matvec lrcm_checker u_lrcm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
